[hw/rtl/sibt_pkg.sv]
// shared types and constants for the sorted interval booking table
package sibt_pkg;

   localparam int TIME_W = 13;
   localparam int COUNT_OUT_W = 7;
   // one day in 1/256 hour units: 24 * 256
   localparam logic [15:0] DAY_LIMIT = 16'(24 * 256);

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_FIND = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_OVERLAP = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] start_time;
      logic [15:0] end_time;
      logic [15:0] room_number;
   } req_type;

   typedef struct packed {
      logic [2:0]             status;
      logic [TIME_W-1:0]      found_end;
      logic [15:0]            found_room;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] slot_start;
      logic [TIME_W-1:0] slot_end;
      logic [15:0]       slot_room;
   } entry_type;

   typedef struct packed {
      logic end_le_key;    // stored end <= key start
      logic start_lt_key;  // stored start < key end
      logic start_eq;      // stored start == key start
      logic start_gt;      // stored start > key start
   } cmp_flags_type;

endpackage

[hw/rtl/sibt_ram.sv]
// generic single write port, single read port ram with registered read
module sibt_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sibt_cmp.sv]
// shared compare unit: one stored entry against the request keys
module sibt_cmp (
   input  sibt_pkg::entry_type                  entry,
   input  logic [sibt_pkg::TIME_W-1:0]          key_start,
   input  logic [sibt_pkg::TIME_W-1:0]          key_end,
   output sibt_pkg::cmp_flags_type              flags
);
   import sibt_pkg::*;

   always_comb begin
      flags.end_le_key = (entry.slot_end <= key_start);
      flags.start_lt_key = (entry.slot_start < key_end);
      flags.start_eq = (entry.slot_start == key_start);
      flags.start_gt = (entry.slot_start > key_start);
   end

endmodule

[hw/rtl/sorted_interval_booking_table.sv]
// top level: sequencer over the interval memory and the shared compare unit
//
//  channel | ports                        | direction | carries
//  req     | req_valid req_ready req_data | in        | action, start, end, room
//  rsp     | rsp_valid rsp_ready rsp_data | out       | status, end, room, count
//
// a request passes through check, then scans entries (a read, then a compare)
// and moves entries (a read, then a write), then ends with end of shift, place
// and response, and returns to idle before the next request; the pace is set
// by the single read and single write port of the entry memory.
// reset clears the count and the sequencer; the memory keeps no reset value.
// req_ready is high only while idle; a finished result waits in its own state
// until the response register is free, so rsp stalls back up into req.
module sorted_interval_booking_table #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sibt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sibt_pkg::rsp_type rsp_data
);
   import sibt_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [2:0]        status_ff, status_in;
   logic [TIME_W-1:0] fend_ff, fend_in;
   logic [15:0]       froom_ff, froom_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   entry_type         wr_data, rd_data;
   logic [ENTRY_W-1:0] rd_bits;
   cmp_flags_type     flags;
   logic [CNT_W-1:0]  ptr_dec, ptr_inc;
   logic [COUNT_OUT_W-1:0] count_low;
   logic              is_insert, out_free;
   entry_type         new_entry;

   sibt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_bits)
   );

   assign rd_data = entry_type'(rd_bits);

   sibt_cmp u_cmp (
      .entry    (rd_data),
      .key_start(req_ff.start_time[TIME_W-1:0]),
      .key_end  (req_ff.end_time[TIME_W-1:0]),
      .flags    (flags)
   );

   generate
      if (CNT_W >= COUNT_OUT_W) begin : g_cnt_trunc
         assign count_low = count_ff[COUNT_OUT_W-1:0];
      end else begin : g_cnt_ext
         assign count_low = {{(COUNT_OUT_W - CNT_W){1'b0}}, count_ff};
      end
   endgenerate

   assign ptr_dec = ptr_ff - CNT_W'(1);
   assign ptr_inc = ptr_ff + CNT_W'(1);
   assign is_insert = (req_ff.action == ACT_INSERT);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign new_entry.slot_start = req_ff.start_time[TIME_W-1:0];
   assign new_entry.slot_end = req_ff.end_time[TIME_W-1:0];
   assign new_entry.slot_room = req_ff.room_number;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      ptr_in = ptr_ff;
      slot_in = slot_ff;
      count_in = count_ff;
      status_in = status_ff;
      fend_in = fend_ff;
      froom_in = froom_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = rd_data;
      rd_en = 1'b0;
      rd_addr = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in = ST_OK;
            fend_in = '0;
            froom_in = '0;
            ptr_in = '0;
            state_in = S_RESP;
            priority if (req_ff.action == ACT_INSERT) begin
               priority if (!(req_ff.start_time < req_ff.end_time)
                            || req_ff.start_time >= DAY_LIMIT
                            || req_ff.end_time >= DAY_LIMIT) begin
                  status_in = ST_INVALID;
               end else if (count_ff == CNT_W'(CAPACITY)) begin
                  status_in = ST_FULL;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end else if (req_ff.action == ACT_FIND || req_ff.action == ACT_REMOVE) begin
               if (req_ff.start_time >= DAY_LIMIT) begin
                  status_in = ST_NOT_FOUND;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end else begin
               status_in = ST_OK;
            end
         end
         S_SCAN_RD: begin
            if (ptr_ff == count_ff) begin
               if (is_insert) begin
                  // slot at the tail, nothing to move
                  slot_in = ptr_ff;
                  ptr_in = count_ff;
                  state_in = S_SHIFT_RD;
               end else begin
                  status_in = ST_NOT_FOUND;
                  state_in = S_RESP;
               end
            end else begin
               rd_en = 1'b1;
               rd_addr = ptr_ff[IDX_W-1:0];
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            ptr_in = ptr_inc;
            state_in = S_SCAN_RD;
            unique case (req_ff.action)
               ACT_INSERT: begin
                  if (!flags.end_le_key) begin
                     if (flags.start_lt_key) begin
                        status_in = ST_OVERLAP;
                        state_in = S_RESP;
                     end else begin
                        slot_in = ptr_ff;
                        ptr_in = count_ff;
                        state_in = S_SHIFT_RD;
                     end
                  end
               end
               ACT_FIND: begin
                  if (flags.start_eq) begin
                     fend_in = rd_data.slot_end;
                     froom_in = rd_data.slot_room;
                     state_in = S_RESP;
                  end
               end
               ACT_REMOVE: begin
                  priority if (flags.start_gt) begin
                     status_in = ST_NOT_FOUND;
                     state_in = S_RESP;
                  end else if (flags.start_eq) begin
                     // pull the entries above down one place
                     state_in = S_SHIFT_RD;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_SHIFT_RD: begin
            if (is_insert) begin
               if (ptr_ff == slot_ff) begin
                  state_in = S_PLACE;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = ptr_dec[IDX_W-1:0];
                  state_in = S_SHIFT_WR;
               end
            end else begin
               if (ptr_ff == count_ff) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_RESP;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = ptr_ff[IDX_W-1:0];
                  state_in = S_SHIFT_WR;
               end
            end
         end
         S_SHIFT_WR: begin
            wr_en = 1'b1;
            wr_data = rd_data;
            if (is_insert) begin
               wr_addr = ptr_ff[IDX_W-1:0];
               ptr_in = ptr_dec;
            end else begin
               wr_addr = ptr_dec[IDX_W-1:0];
               ptr_in = ptr_inc;
            end
            state_in = S_SHIFT_RD;
         end
         S_PLACE: begin
            wr_en = 1'b1;
            wr_addr = slot_ff[IDX_W-1:0];
            wr_data = new_entry;
            count_in = count_ff + CNT_W'(1);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.found_end = fend_ff;
               rsp_in.found_room = froom_ff;
               rsp_in.entry_count = count_low;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      ptr_ff <= ptr_in;
      slot_ff <= slot_in;
      status_ff <= status_in;
      fend_ff <= fend_in;
      froom_ff <= froom_in;
      rsp_ff <= rsp_in;
   end

endmodule

[verif/sorted_interval_booking_table_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the sorted interval booking table
module sorted_interval_booking_table_tb;
   import sibt_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS = 300;
   localparam int FILL_ITEMS = 200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 10;

   class booking_scoreboard;
      logic [TIME_W-1:0] start_tab [TABLE_DEPTH];
      logic [TIME_W-1:0] end_tab [TABLE_DEPTH];
      logic [15:0] room_tab [TABLE_DEPTH];
      int unsigned n_stored = 0;
      int unsigned peak_stored = 0;
      int unsigned status_hits [5];
      int unsigned mismatches = 0;
      int unsigned checked = 0;
      rsp_type pending_rsp [$];

      // apply one accepted request to the shadow table and queue its response
      function void note_request(req_type r);
         rsp_type exp;
         int unsigned slot;
         int unsigned k;
         exp = '0;
         case (r.action)
            ACT_INSERT: begin
               if (!(r.start_time < r.end_time) || r.start_time >= DAY_LIMIT
                     || r.end_time >= DAY_LIMIT) begin
                  exp.status = ST_INVALID;
               end else if (n_stored >= TABLE_DEPTH) begin
                  exp.status = ST_FULL;
               end else begin
                  slot = 0;
                  while (slot < n_stored && end_tab[slot] <= r.start_time) slot++;
                  if (slot < n_stored && start_tab[slot] < r.end_time) begin
                     exp.status = ST_OVERLAP;
                  end else begin
                     for (k = n_stored; k > slot; k--) begin
                        start_tab[k] = start_tab[k-1];
                        end_tab[k] = end_tab[k-1];
                        room_tab[k] = room_tab[k-1];
                     end
                     start_tab[slot] = r.start_time[TIME_W-1:0];
                     end_tab[slot] = r.end_time[TIME_W-1:0];
                     room_tab[slot] = r.room_number;
                     n_stored++;
                     exp.status = ST_OK;
                  end
               end
            end
            ACT_FIND: begin
               exp.status = ST_NOT_FOUND;
               if (r.start_time < DAY_LIMIT) begin
                  for (k = 0; k < n_stored; k++) begin
                     if (start_tab[k] == r.start_time) begin
                        exp.status = ST_OK;
                        exp.found_end = end_tab[k];
                        exp.found_room = room_tab[k];
                        break;
                     end
                  end
               end
            end
            ACT_REMOVE: begin
               exp.status = ST_NOT_FOUND;
               if (r.start_time < DAY_LIMIT) begin
                  for (k = 0; k < n_stored; k++) begin
                     // starts are sorted, so the scan stops once they pass the key
                     if (start_tab[k] > r.start_time) break;
                     if (start_tab[k] == r.start_time) begin
                        for (slot = k + 1; slot < n_stored; slot++) begin
                           start_tab[slot-1] = start_tab[slot];
                           end_tab[slot-1] = end_tab[slot];
                           room_tab[slot-1] = room_tab[slot];
                        end
                        n_stored--;
                        exp.status = ST_OK;
                        break;
                     end
                  end
               end
            end
            default: exp.status = ST_OK;
         endcase
         exp.entry_count = COUNT_OUT_W'(n_stored);
         if (n_stored > peak_stored) peak_stored = n_stored;
         status_hits[exp.status]++;
         pending_rsp.push_back(exp);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response: status %0d end %0d room %0d count %0d",
                     $time, got.status, got.found_end, got.found_room, got.entry_count);
         end else begin
            exp = pending_rsp.pop_front();
            checked++;
            if (got !== exp) begin
               mismatches++;
               $display("%0t: mismatch: expected status %0d end %0d room %0d count %0d",
                        $time, exp.status, exp.found_end, exp.found_room,
                        exp.entry_count);
               $display("%0t:           actual   status %0d end %0d room %0d count %0d",
                        $time, got.status, got.found_end, got.found_room,
                        got.entry_count);
            end
         end
      endfunction

      function logic [15:0] random_stored_start();
         if (n_stored == 0) return 16'($urandom_range(0, 767) * 8);
         return 16'(start_tab[$urandom_range(0, n_stored - 1)]);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_left = 0;
   int quiet_cycles = 0;
   int unsigned sent = 0;
   booking_scoreboard sb = new();

   sorted_interval_booking_table #(
      .CAPACITY(TABLE_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: random stalls, or a long hold-off when one is pending
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no request or response for %0d cycles", $time,
                  WATCHDOG_LIMIT);
         $display("** sorted_interval_booking_table: FAILED **");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_op(input logic [1:0] act, input logic [15:0] s,
                          input logic [15:0] e, input logic [15:0] room);
      req_type r;
      r.action = act;
      r.start_time = s;
      r.end_time = e;
      r.room_number = room;
      send_request(r);
   endtask

   // mostly well-formed bookings on an 8-unit grid so that neighbors touch
   function automatic req_type make_request(int insert_pct);
      req_type r;
      int unsigned len;
      r.room_number = 16'($urandom);
      r.end_time = 16'($urandom);
      if ($urandom_range(0, 99) < 5) begin
         r.action = 2'($urandom_range(0, 3));
         r.start_time = 16'($urandom);
      end else if ($urandom_range(0, 99) < insert_pct) begin
         r.action = ACT_INSERT;
         r.start_time = 16'($urandom_range(0, 767) * 8);
         len = 8 * $urandom_range(1, 8);
         r.end_time = (r.start_time + len >= DAY_LIMIT) ? DAY_LIMIT - 16'd1
                                                       : 16'(r.start_time + len);
         if ($urandom_range(0, 99) < 6) begin
            case ($urandom_range(0, 2))
               0: r.end_time = r.start_time - 16'($urandom_range(0, 8));
               1: r.start_time = 16'($urandom_range(DAY_LIMIT, 65535));
               default: r.end_time = 16'($urandom_range(DAY_LIMIT, 65535));
            endcase
         end
      end else begin
         r.action = $urandom_range(0, 1) ? ACT_FIND : ACT_REMOVE;
         r.start_time = sb.random_stored_start();
         // near misses move the start up by 1 to 16 units from a stored start
         if ($urandom_range(0, 99) < 25) r.start_time += 16'($urandom_range(1, 16));
      end
      return r;
   endfunction

   initial begin
      int insert_pct;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_op(ACT_FIND, 16'd0, 16'd0, 16'd0);
      send_op(ACT_REMOVE, 16'd0, 16'd0, 16'd0);
      send_op(ACT_INSERT, 16'd5, 16'd5, 16'd7);
      send_op(ACT_INSERT, 16'd300, 16'd200, 16'd7);
      send_op(ACT_INSERT, 16'd6144, 16'd6200, 16'd7);
      send_op(ACT_INSERT, 16'd100, 16'd6144, 16'd7);
      send_op(ACT_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_op(ACT_INSERT, 16'd0, 16'd6143, 16'hFFFF);
      send_op(ACT_FIND, 16'd0, 16'hFFFF, 16'd0);
      send_op(ACT_INSERT, 16'd100, 16'd200, 16'd0);
      send_op(ACT_FIND, 16'd6143, 16'd0, 16'd0);
      send_op(ACT_REMOVE, 16'd0, 16'd0, 16'd0);
      send_op(ACT_INSERT, 16'd100, 16'd200, 16'd1);
      send_op(ACT_INSERT, 16'd200, 16'd300, 16'd2);
      send_op(ACT_INSERT, 16'd50, 16'd100, 16'd3);
      send_op(ACT_INSERT, 16'd150, 16'd250, 16'd4);
      send_op(ACT_INSERT, 16'd0, 16'd6143, 16'd5);
      send_op(ACT_INSERT, 16'd40, 16'd60, 16'd6);
      send_op(ACT_FIND, 16'd200, 16'd0, 16'd0);
      send_op(ACT_FIND, 16'd6144, 16'd0, 16'd0);
      send_op(ACT_REMOVE, 16'd150, 16'd0, 16'd0);
      send_op(ACT_REMOVE, 16'd6000, 16'd0, 16'd0);
      send_op(ACT_UNUSED, 16'd1234, 16'd4321, 16'hA5A5);
      send_op(ACT_REMOVE, 16'd100, 16'd0, 16'd0);
      send_op(ACT_REMOVE, 16'hFFFF, 16'd0, 16'd0);

      // long response hold-off while requests keep coming
      @(posedge clock);
      hold_off_left = HOLD_OFF_CYCLES;
      @(negedge clock);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 75; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 75; end
            default: begin send_idle_pct = 16; rsp_stall_pct = 16; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // fill toward capacity, then drain
            insert_pct = (i < FILL_ITEMS) ? 85 : 15;
            send_request(make_request(insert_pct));
         end
      end
      req_valid <= 1'b0;

      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests (%0d checked): directed corner cases, then four idle/stall mixes with a long response hold-off",
               sent, sb.checked);
      $display("statuses ok %0d invalid %0d overlap %0d full %0d not-found %0d, peak fill %0d of %0d",
               sb.status_hits[ST_OK], sb.status_hits[ST_INVALID], sb.status_hits[ST_OVERLAP],
               sb.status_hits[ST_FULL], sb.status_hits[ST_NOT_FOUND], sb.peak_stored,
               TABLE_DEPTH);
      if (sb.mismatches == 0) begin
         $display("** sorted_interval_booking_table: PASSED **");
      end else begin
         $display("** sorted_interval_booking_table: FAILED **");
      end
      $finish;
   end

endmodule
